/* design/cau_pkg.sv */
`default_nettype none
package cau_pkg;

	localparam int WORD_BITS = 16;
	localparam int FRAC_BITS = 12;

	// Product, widened sum, and numerator magnitude widths.
	localparam int PW = 2 * WORD_BITS;
	localparam int SW = PW + 1;
	localparam int NW = PW + FRAC_BITS;
	// Quotient magnitude bits: one cell per bit.
	localparam int QW = WORD_BITS + 1;
	// Remainder and shifted divisor width.
	localparam int CW = (NW > PW + QW) ? NW : PW + QW;

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_SUB = 2'd1;
	localparam logic [1:0] CMD_MUL = 2'd2;
	localparam logic [1:0] CMD_DIV = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIVZ = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [SW:0] wide_t;

	localparam wide_t MAXV = wide_t'((longint'(1) <<< (WORD_BITS - 1)) - longint'(1));
	localparam wide_t MINV = wide_t'(-(longint'(1) <<< (WORD_BITS - 1)));
	localparam logic [QW-1:0] QMAX_POS = QW'((longint'(1) <<< (WORD_BITS - 1)) - longint'(1));
	localparam logic [QW-1:0] QMAX_NEG = QW'(longint'(1) <<< (WORD_BITS - 1));

	typedef struct packed {
		word_t val;
		logic  flag;
	} sat_t;

	typedef struct packed {
		logic            valid;
		logic            is_div;
		logic            zero;
		logic            ovf_re;
		logic            ovf_im;
		logic            neg_re;
		logic            neg_im;
		logic [CW-1:0]   rem_re;
		logic [CW-1:0]   rem_im;
		logic [CW-1:0]   dsh;
		logic [QW-1:0]   q_re;
		logic [QW-1:0]   q_im;
		word_t           res_re;
		word_t           res_im;
		logic [1:0]      status;
	} cell_t;

	function automatic sat_t sat_wide(input wide_t v);
		sat_t r;
		if (v > MAXV) begin
			r.val  = word_t'(MAXV);
			r.flag = 1'b1;
		end else if (v < MINV) begin
			r.val  = word_t'(MINV);
			r.flag = 1'b1;
		end else begin
			r.val  = word_t'(v);
			r.flag = 1'b0;
		end
		return r;
	endfunction

	// Applies the sign to a quotient magnitude and clamps it to the word.
	function automatic sat_t sat_quot(input logic [QW-1:0] q, input logic neg,
		input logic ovf);
		sat_t r;
		if (!neg && (ovf || q > QMAX_POS)) begin
			r.val  = word_t'(MAXV);
			r.flag = 1'b1;
		end else if (neg && (ovf || q > QMAX_NEG)) begin
			r.val  = word_t'(MINV);
			r.flag = 1'b1;
		end else begin
			r.val  = neg ? word_t'(-q) : word_t'(q);
			r.flag = 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* design/cau_req_if.sv */
`default_nettype none
interface cau_req_if;
	logic           valid;
	logic           ready;
	logic [1:0]     cmd;
	cau_pkg::word_t a_re;
	cau_pkg::word_t a_im;
	cau_pkg::word_t b_re;
	cau_pkg::word_t b_im;

	modport source(output valid, cmd, a_re, a_im, b_re, b_im, input ready);
	modport sink(input valid, cmd, a_re, a_im, b_re, b_im, output ready);
	modport mon(input valid, ready, cmd, a_re, a_im, b_re, b_im);
endinterface
`default_nettype wire

/* design/cau_rsp_if.sv */
`default_nettype none
interface cau_rsp_if;
	logic           valid;
	logic           ready;
	cau_pkg::word_t res_re;
	cau_pkg::word_t res_im;
	logic [1:0]     status;

	modport source(output valid, res_re, res_im, status, input ready);
	modport sink(input valid, res_re, res_im, status, output ready);
	modport mon(input valid, ready, res_re, res_im, status);
endinterface
`default_nettype wire

/* design/cau_front.sv */
`default_nettype none
module cau_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire logic [1:0]     cmd,
	input  wire cau_pkg::word_t a_re,
	input  wire cau_pkg::word_t a_im,
	input  wire cau_pkg::word_t b_re,
	input  wire cau_pkg::word_t b_im,
	output cau_pkg::cell_t      head
);
	import cau_pkg::*;

	logic                 valid_s1;
	logic [1:0]           cmd_s1;
	logic signed [PW-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, p_bb_s1, p_cc_s1;
	logic signed [WORD_BITS:0] sum_re_s1, sum_im_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1  <= cmd;
			p_rr_s1 <= a_re * b_re;
			p_ii_s1 <= a_im * b_im;
			p_ri_s1 <= a_re * b_im;
			p_ir_s1 <= a_im * b_re;
			p_bb_s1 <= b_re * b_re;
			p_cc_s1 <= b_im * b_im;
			if (cmd == CMD_SUB) begin
				sum_re_s1 <= (WORD_BITS+1)'(a_re) - (WORD_BITS+1)'(b_re);
				sum_im_s1 <= (WORD_BITS+1)'(a_im) - (WORD_BITS+1)'(b_im);
			end else begin
				sum_re_s1 <= (WORD_BITS+1)'(a_re) + (WORD_BITS+1)'(b_re);
				sum_im_s1 <= (WORD_BITS+1)'(a_im) + (WORD_BITS+1)'(b_im);
			end
		end
	end

	logic signed [SW-1:0] mul_re, mul_im, num_re, num_im;
	logic [SW-1:0]        mag_re, mag_im;
	logic [PW-1:0]        den;
	logic [CW-1:0]        dfull, n_re, n_im;
	sat_t                 s_re, s_im;
	cell_t                nxt;

	always_comb begin
		mul_re = SW'(p_rr_s1) - SW'(p_ii_s1);
		mul_im = SW'(p_ri_s1) + SW'(p_ir_s1);
		num_re = SW'(p_rr_s1) + SW'(p_ii_s1);
		num_im = SW'(p_ir_s1) - SW'(p_ri_s1);
		den    = PW'(p_bb_s1) + PW'(p_cc_s1);
		mag_re = num_re[SW-1] ? SW'(-num_re) : SW'(num_re);
		mag_im = num_im[SW-1] ? SW'(-num_im) : SW'(num_im);
		n_re   = CW'(mag_re) << FRAC_BITS;
		n_im   = CW'(mag_im) << FRAC_BITS;
		dfull  = CW'(den);

		if (cmd_s1 == CMD_MUL) begin
			s_re = sat_wide(wide_t'(mul_re >>> FRAC_BITS));
			s_im = sat_wide(wide_t'(mul_im >>> FRAC_BITS));
		end else begin
			s_re = sat_wide(wide_t'(sum_re_s1));
			s_im = sat_wide(wide_t'(sum_im_s1));
		end

		nxt.valid  = valid_s1;
		nxt.is_div = (cmd_s1 == CMD_DIV);
		nxt.zero   = (den == '0);
		// A quotient of 2^QW or more can only saturate, so the cells need not see it.
		nxt.ovf_re = n_re >= (dfull << QW);
		nxt.ovf_im = n_im >= (dfull << QW);
		nxt.neg_re = num_re[SW-1];
		nxt.neg_im = num_im[SW-1];
		nxt.rem_re = n_re;
		nxt.rem_im = n_im;
		nxt.dsh    = dfull << (QW - 1);
		nxt.q_re   = '0;
		nxt.q_im   = '0;
		nxt.res_re = s_re.val;
		nxt.res_im = s_im.val;
		nxt.status = (s_re.flag || s_im.flag) ? ST_SAT : ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head <= '0;
		end else if (en) begin
			head <= nxt;
		end
	end
endmodule
`default_nettype wire

/* design/cau_div_cell.sv */
`default_nettype none
module cau_div_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire cau_pkg::cell_t prev,
	output cau_pkg::cell_t      next
);
	import cau_pkg::*;

	// One restoring step for both parts; the divisor walks one bit lower per cell.
	logic  ge_re, ge_im;
	cell_t nxt;

	always_comb begin
		ge_re      = prev.rem_re >= prev.dsh;
		ge_im      = prev.rem_im >= prev.dsh;
		nxt        = prev;
		nxt.rem_re = ge_re ? prev.rem_re - prev.dsh : prev.rem_re;
		nxt.rem_im = ge_im ? prev.rem_im - prev.dsh : prev.rem_im;
		nxt.q_re   = {prev.q_re[QW-2:0], ge_re};
		nxt.q_im   = {prev.q_im[QW-2:0], ge_im};
		nxt.dsh    = prev.dsh >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next <= '0;
		end else if (en) begin
			next <= nxt;
		end
	end
endmodule
`default_nettype wire

/* design/complex_arithmetic_unit_top.sv */
// Channel | Modport | Payload                      | Transaction
// req     | sink    | cmd, a_re, a_im, b_re, b_im  | valid && ready
// rsp     | source  | res_re, res_im, status       | valid && ready
//
// Fully pipelined: one transaction per cycle through WORD_BITS + 4 register stages
// (20 at 16 bits): product register, combine register, one divider cell per
// quotient bit (WORD_BITS + 1 cells), and the output register. All stages advance
// together; the whole pipe holds while rsp is stalled with a result pending, and
// req.ready drops in exactly those cycles.
// Reset clears the valid bits and the divider chain registers.
`default_nettype none
module complex_arithmetic_unit_top (
	input wire logic clk,
	input wire logic arst_n,
	cau_req_if.sink  req,
	cau_rsp_if.source rsp
);
	import cau_pkg::*;

	logic  en;
	logic  valid_q;
	word_t res_re_q, res_im_q;
	logic [1:0] status_q;
	cell_t chain [QW+1];

	assign en        = !valid_q || rsp.ready;
	assign req.ready = en;

	cau_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (req.valid),
		.cmd      (req.cmd),
		.a_re     (req.a_re),
		.a_im     (req.a_im),
		.b_re     (req.b_re),
		.b_im     (req.b_im),
		.head     (chain[0])
	);

	for (genvar i = 0; i < QW; i++) begin : g_cell
		cau_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.prev   (chain[i]),
			.next   (chain[i+1])
		);
	end

	cell_t      tail;
	sat_t       q_re, q_im;
	word_t      fin_re, fin_im;
	logic [1:0] fin_st;

	always_comb begin
		tail = chain[QW];
		q_re = sat_quot(tail.q_re, tail.neg_re, tail.ovf_re);
		q_im = sat_quot(tail.q_im, tail.neg_im, tail.ovf_im);
		if (!tail.is_div) begin
			fin_re = tail.res_re;
			fin_im = tail.res_im;
			fin_st = tail.status;
		end else if (tail.zero) begin
			fin_re = '0;
			fin_im = '0;
			fin_st = ST_DIVZ;
		end else begin
			fin_re = q_re.val;
			fin_im = q_im.val;
			fin_st = (q_re.flag || q_im.flag) ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_re_q <= fin_re;
			res_im_q <= fin_im;
			status_q <= fin_st;
		end
	end

	assign rsp.valid  = valid_q;
	assign rsp.res_re = res_re_q;
	assign rsp.res_im = res_im_q;
	assign rsp.status = status_q;
endmodule
`default_nettype wire

/* design/cau_checker.sv */
`default_nettype none
module cau_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_ready,
	input wire logic           rsp_valid,
	input wire logic           rsp_ready,
	input wire cau_pkg::word_t res_re,
	input wire cau_pkg::word_t res_im,
	input wire logic [1:0]     status
);
	import cau_pkg::*;

	// A result that is held back keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(res_re)
			&& $stable(res_im) && $stable(status))
		else $error("rsp changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status == ST_OK || status == ST_DIVZ
			|| status == ST_SAT)
		else $error("unknown status code");

	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_DIVZ |-> res_re == '0 && res_im == '0)
		else $error("division by zero with nonzero result");

	// The pipe holds as a whole, so no new transaction enters behind a stalled result.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("req accepted while output stalled");
endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.res_re    (rsp.res_re),
	.res_im    (rsp.res_im),
	.status    (rsp.status)
);
`default_nettype wire

/* tb/sv/cau_scoreboard.sv */
`timescale 1ns / 1ps
import cau_pkg::*;

class cau_scoreboard;
	typedef struct {
		word_t      re;
		word_t      im;
		logic [1:0] status;
	} cplx_result_t;

	cplx_result_t pending_results[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	// Clamps an exact value to the word and raises the flag when it had to.
	static function word_t clamp_word(input longint v, inout bit clipped);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (WORD_BITS - 1)) - 1;
		lo = -(longint'(1) <<< (WORD_BITS - 1));
		if (v > hi) begin
			clipped = 1;
			return word_t'(hi);
		end
		if (v < lo) begin
			clipped = 1;
			return word_t'(lo);
		end
		return word_t'(v);
	endfunction

	// Integer division that truncates toward zero, for a positive divisor.
	static function longint div_trunc(input longint n, input longint d);
		longint m;
		m = (n < 0) ? -n : n;
		m = m / d;
		return (n < 0) ? -m : m;
	endfunction

	function void note_request(input logic [1:0] cmd, input word_t ar, input word_t ai,
		input word_t br, input word_t bi);
		cplx_result_t r;
		longint xr;
		longint xi;
		longint den;
		bit clipped;
		clipped = 0;
		case (cmd)
			CMD_ADD: begin
				xr = longint'(ar) + longint'(br);
				xi = longint'(ai) + longint'(bi);
			end
			CMD_SUB: begin
				xr = longint'(ar) - longint'(br);
				xi = longint'(ai) - longint'(bi);
			end
			CMD_MUL: begin
				xr = (longint'(ar) * br - longint'(ai) * bi) >>> FRAC_BITS;
				xi = (longint'(ar) * bi + longint'(ai) * br) >>> FRAC_BITS;
			end
			default: begin
				den = longint'(br) * br + longint'(bi) * bi;
				if (den == 0) begin
					r.re = '0;
					r.im = '0;
					r.status = ST_DIVZ;
					pending_results = {pending_results, r};
					return;
				end
				xr = div_trunc((longint'(ar) * br + longint'(ai) * bi) <<< FRAC_BITS, den);
				xi = div_trunc((longint'(ai) * br - longint'(ar) * bi) <<< FRAC_BITS, den);
			end
		endcase
		r.re = clamp_word(xr, clipped);
		r.im = clamp_word(xi, clipped);
		r.status = clipped ? ST_SAT : ST_OK;
		pending_results = {pending_results, r};
	endfunction

	function void check_result(input word_t re, input word_t im, input logic [1:0] status);
		cplx_result_t e;
		if (pending_results.size() == 0) begin
			$error("unexpected result re=%0d im=%0d status=%0d", re, im, status);
			errors++;
			return;
		end
		e = pending_results.pop_front();
		if (re !== e.re) begin
			$error("res_re: expected %0d, got %0d", e.re, re);
			errors++;
		end
		if (im !== e.im) begin
			$error("res_im: expected %0d, got %0d", e.im, im);
			errors++;
		end
		if (status !== e.status) begin
			$error("status: expected %0d, got %0d", e.status, status);
			errors++;
		end
	endfunction
endclass

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
	import cau_pkg::*;

	localparam int LATENCY = WORD_BITS + 4;
	localparam int RANDOM_ITEMS = 1750;

	logic clk;
	logic arst_n;
	cau_req_if req();
	cau_rsp_if rsp();
	cau_scoreboard results;
	bit rsp_stall_mode;
	int rsp_phase;

	complex_arithmetic_unit_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic word_t pick_word();
		case ($urandom_range(0, 9))
			0: return word_t'(16'sh7fff);
			1: return word_t'(16'sh8000);
			2: return '0;
			3: return word_t'(int'($urandom_range(0, 15)) - 8);
			4: return word_t'(int'($urandom_range(0, 8191)) - 4096);
			default: return word_t'($urandom());
		endcase
	endfunction

	// Presents one transaction and holds it until the block takes it.
	task automatic send_request(input logic [1:0] cmd, input word_t ar, input word_t ai,
		input word_t br, input word_t bi);
		req.valid <= 1'b1;
		req.cmd <= cmd;
		req.a_re <= ar;
		req.a_im <= ai;
		req.b_re <= br;
		req.b_im <= bi;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic pause_sender(input int cycles);
		req.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Monitor: transactions are sampled at the edge, before the nonblocking updates land.
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready)
			results.note_request(req.cmd, req.a_re, req.a_im, req.b_re, req.b_im);
		if (arst_n && rsp.valid && rsp.ready)
			results.check_result(rsp.res_re, rsp.res_im, rsp.status);
	end

	// The receiver alternates between free running and stalling on a duty pattern.
	always @(posedge clk) begin
		rsp_phase <= rsp_phase + 1;
		if (rsp_phase % 200 == 0)
			rsp_stall_mode <= $urandom_range(0, 1);
		if (!rsp_stall_mode)
			rsp.ready <= 1'b1;
		else
			rsp.ready <= ($urandom_range(0, 3) != 0) && (rsp_phase % 7 != 3);
	end

	initial begin
		int wait_cycles;
		word_t w [4];
		results = new();
		rsp_stall_mode = 0;
		rsp_phase = 0;
		arst_n = 0;
		req.valid = 0;
		req.cmd = CMD_ADD;
		req.a_re = '0;
		req.a_im = '0;
		req.b_re = '0;
		req.b_im = '0;
		rsp.ready = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes of every operation, saturation and the zero divisor.
		w = '{word_t'(16'sh7fff), word_t'(16'sh8000), word_t'(0), word_t'(16'sh1000)};
		for (int c = 0; c < 4; c++) begin
			send_request(c[1:0], w[0], w[1], w[0], w[1]);
			send_request(c[1:0], w[1], w[1], w[1], w[1]);
			send_request(c[1:0], w[3], w[0], w[3], w[2]);
		end
		send_request(CMD_DIV, w[0], w[1], '0, '0);
		send_request(CMD_DIV, '0, '0, '0, '0);
		send_request(CMD_DIV, w[3], w[3], word_t'(1), '0);
		send_request(CMD_DIV, w[0], w[0], '0, word_t'(-1));
		send_request(CMD_MUL, word_t'(-1), word_t'(1), word_t'(1), word_t'(1));
		send_request(CMD_SUB, w[1], w[0], w[0], w[1]);

		// Let the pipe drain completely once before the random part.
		pause_sender(1);
		wait_cycles = 0;
		while (results.pending_results.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end

		for (int n = 0; n < RANDOM_ITEMS; ) begin
			int burst;
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && n < RANDOM_ITEMS; k++, n++) begin
				logic [1:0] cmd;
				cmd = 2'($urandom_range(0, 3));
				if (cmd == CMD_DIV && $urandom_range(0, 15) == 0)
					send_request(cmd, pick_word(), pick_word(), '0, '0);
				else
					send_request(cmd, pick_word(), pick_word(), pick_word(), pick_word());
			end
			if ($urandom_range(0, 3) != 0)
				pause_sender($urandom_range(1, 12));
		end
		pause_sender(1);

		wait_cycles = 0;
		while (results.pending_results.size() != 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (LATENCY + 10) @(posedge clk);
		if (results.errors == 0 && results.pending_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
